// ===== hdl/tplm_pkg.sv =====
// ----------------------------------------------------------------------------
// tplm_pkg
// Shared types, constants and a helper function of the tree parameter masker.
// ----------------------------------------------------------------------------
package tplm_pkg;

    localparam int NUM_STREAMS = 4;

    localparam logic [1:0] STRM_U = 2'd0;
    localparam logic [1:0] STRM_Z = 2'd1;
    localparam logic [1:0] STRM_V = 2'd2;
    localparam logic [1:0] STRM_E = 2'd3;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam int LEN_W  = 6;

    localparam logic [CFG_AW-1:0] CFG_SEED_U = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SEED_Z = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SEED_V = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SEED_E = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LEN_U  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_LEN_Z  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_LEN_V  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_LEN_E  = 3'd7;

    localparam logic [31:0] SEED_U_RST = 32'd12345;
    localparam logic [31:0] SEED_Z_RST = 32'd123;
    localparam logic [31:0] SEED_V_RST = 32'd123456;
    localparam logic [31:0] SEED_E_RST = 32'd1357;

    localparam logic [LEN_W-1:0] LEN_U_RST = 6'd40;
    localparam logic [LEN_W-1:0] LEN_Z_RST = 6'd32;
    localparam logic [LEN_W-1:0] LEN_V_RST = 6'd30;
    localparam logic [LEN_W-1:0] LEN_E_RST = 6'd30;

    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_INC  = 32'd1013904223;
    // Two LCG steps folded into one affine map.
    localparam logic [31:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
    localparam logic [31:0] LCG_INC2 = 32'(64'(LCG_MUL) * 64'(LCG_INC) + 64'(LCG_INC));

    localparam logic [63:0] LEAF_MARK = 64'hFFFF_FFFF_FFFF_CC58;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic               new_tree;
        logic signed [63:0] threshold_in;
        logic signed [63:0] weight_in;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] threshold_out;
        logic signed [63:0] weight_out;
        logic               node_is_leaf;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [63:0] thr;
        logic [63:0] wgt;
        logic [63:0] du;
        logic [63:0] dz;
        logic [63:0] dv;
        logic [63:0] de;
        logic        leaf;
    } t_q_entry;

    function automatic logic [63:0] lcg_draw(input logic [63:0] joined,
                                             input logic [LEN_W-1:0] len);
        logic [63:0] mask;
        logic [63:0] half;
        mask = ~({64{1'b1}} << len);
        half = (len == '0) ? 64'd0 : (64'd1 << (len - 6'd1));
        return (joined & mask) - half;
    endfunction

endpackage

// ===== hdl/tplm_front.sv =====
// ----------------------------------------------------------------------------
// tplm_front
// Holds configuration and stream state, accepts nodes and forms the draws.
// ----------------------------------------------------------------------------
module tplm_front
    import tplm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_q_vld,
    output t_q_entry o_q_entry,
    input  logic     i_q_full
);

    logic [31:0]      r_seed [NUM_STREAMS];
    logic [LEN_W-1:0] r_len  [NUM_STREAMS];
    logic [31:0]      r_lcg  [NUM_STREAMS];
    logic [31:0]      n_lcg  [NUM_STREAMS];
    logic [63:0]      n_joined [NUM_STREAMS];
    logic [63:0]      r_joined [NUM_STREAMS];
    logic [31:0]      r_tree_cnt;
    logic             r_hold_vld;
    logic [63:0]      r_hold_thr;
    logic [63:0]      r_hold_wgt;
    logic             w_accept;
    logic             w_push;
    logic             w_start;

    assign w_push     = r_hold_vld && !i_q_full;
    assign o_in_stall = r_hold_vld && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = i_in_data.new_tree || (r_tree_cnt == 32'd0);

    always_comb begin
        logic [31:0] base;
        logic [31:0] hi;
        logic [31:0] lo;
        for (int k = 0; k < NUM_STREAMS; k++) begin
            base = w_start ? (r_seed[k] + r_tree_cnt) : r_lcg[k];
            hi   = base * LCG_MUL + LCG_INC;
            lo   = base * LCG_MUL2 + LCG_INC2;
            n_lcg[k]    = lo;
            n_joined[k] = {hi, lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed[STRM_U] <= SEED_U_RST;
            r_seed[STRM_Z] <= SEED_Z_RST;
            r_seed[STRM_V] <= SEED_V_RST;
            r_seed[STRM_E] <= SEED_E_RST;
            r_len[STRM_U]  <= LEN_U_RST;
            r_len[STRM_Z]  <= LEN_Z_RST;
            r_len[STRM_V]  <= LEN_V_RST;
            r_len[STRM_E]  <= LEN_E_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.addr)
                CFG_SEED_U: r_seed[STRM_U] <= i_cfg.data;
                CFG_SEED_Z: r_seed[STRM_Z] <= i_cfg.data;
                CFG_SEED_V: r_seed[STRM_V] <= i_cfg.data;
                CFG_SEED_E: r_seed[STRM_E] <= i_cfg.data;
                CFG_LEN_U:  r_len[STRM_U]  <= i_cfg.data[LEN_W-1:0];
                CFG_LEN_Z:  r_len[STRM_Z]  <= i_cfg.data[LEN_W-1:0];
                CFG_LEN_V:  r_len[STRM_V]  <= i_cfg.data[LEN_W-1:0];
                CFG_LEN_E:  r_len[STRM_E]  <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_cnt <= 32'd0;
            r_hold_vld <= 1'b0;
            for (int k = 0; k < NUM_STREAMS; k++) begin
                r_lcg[k] <= 32'd0;
            end
        end else begin
            if (w_accept) begin
                r_hold_vld <= 1'b1;
                for (int k = 0; k < NUM_STREAMS; k++) begin
                    r_lcg[k] <= n_lcg[k];
                end
                if (w_start) begin
                    r_tree_cnt <= r_tree_cnt + 32'd1;
                end
            end else if (w_push) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_thr <= i_in_data.threshold_in;
            r_hold_wgt <= i_in_data.weight_in;
            for (int k = 0; k < NUM_STREAMS; k++) begin
                r_joined[k] <= n_joined[k];
            end
        end
    end

    assign o_q_vld         = w_push;
    assign o_q_entry.thr   = r_hold_thr;
    assign o_q_entry.wgt   = r_hold_wgt;
    assign o_q_entry.du    = lcg_draw(r_joined[STRM_U], r_len[STRM_U]);
    assign o_q_entry.dz    = lcg_draw(r_joined[STRM_Z], r_len[STRM_Z]);
    assign o_q_entry.dv    = lcg_draw(r_joined[STRM_V], r_len[STRM_V]);
    assign o_q_entry.de    = lcg_draw(r_joined[STRM_E], r_len[STRM_E]);
    assign o_q_entry.leaf  = (r_hold_thr == LEAF_MARK);

endmodule

// ===== hdl/tplm_fifo.sv =====
// ----------------------------------------------------------------------------
// tplm_fifo
// Short queue that decouples the draw front end from the masking back end.
// ----------------------------------------------------------------------------
module tplm_fifo
    import tplm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    output logic     o_vld,
    output t_q_entry o_entry,
    input  logic     i_pop
);

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/tplm_back.sv =====
// ----------------------------------------------------------------------------
// tplm_back
// Applies the masks: a three-step 32x32 multiply for internal nodes and a
// single add for leaves, followed by the output register.
// ----------------------------------------------------------------------------
module tplm_back
    import tplm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_vld,
    input  t_q_entry  i_q_entry,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam logic [1:0] STEP_LL   = 2'd0;
    localparam logic [1:0] STEP_LH   = 2'd1;
    localparam logic [1:0] STEP_HL   = 2'd2;
    localparam logic [1:0] STEP_DONE = 2'd3;

    logic        r_busy;
    logic [1:0]  r_step;
    logic [63:0] r_acc;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_wgt;
    logic        r_leaf;
    logic        r_out_vld;
    t_out_item   r_out;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_addend;
    logic        w_done;

    assign o_q_pop = i_q_vld && !r_busy;
    assign w_done  = r_busy && (r_step == STEP_DONE) && (!r_out_vld || !i_out_stall);

    always_comb begin
        case (r_step)
            STEP_LL: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            STEP_LH: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
            STEP_HL: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
        w_prod   = 64'(w_ma) * 64'(w_mb);
        w_addend = (r_step == STEP_LL) ? w_prod : {w_prod[31:0], 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= STEP_LL;
            r_out_vld <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_step <= i_q_entry.leaf ? STEP_DONE : STEP_LL;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && (r_step != STEP_DONE)) begin
                r_step <= r_step + 2'd1;
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a    <= i_q_entry.du;
            r_b    <= i_q_entry.thr;
            r_wgt  <= i_q_entry.wgt;
            r_leaf <= i_q_entry.leaf;
            r_acc  <= i_q_entry.leaf ? (i_q_entry.wgt + i_q_entry.de)
                                     : (i_q_entry.dv + i_q_entry.dz);
        end else if (r_busy && (r_step != STEP_DONE)) begin
            r_acc <= r_acc + w_addend;
        end
        if (w_done) begin
            r_out.threshold_out <= r_leaf ? r_b : r_acc;
            r_out.weight_out    <= r_leaf ? r_acc : r_wgt;
            r_out.node_is_leaf  <= r_leaf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/tree_param_lcg_masker_unit.sv =====
// ----------------------------------------------------------------------------
// tree_param_lcg_masker_unit
// Masks decision-tree node parameters with four LCG streams, one node per item.
// ----------------------------------------------------------------------------
// Usage: nodes enter on i_in_valid/o_in_stall with payload i_in_data; masked
// nodes leave on o_out_valid/i_out_stall with payload o_out_data. A request is
// taken at a rising edge with valid high and stall low.
// Registers are to be written through i_cfg_we, i_cfg_addr and i_cfg_data only
// while the block is idle, which the block does not enforce; no read-back.
// While o_in_stall is low, the front end takes one request per cycle into a
// holding stage, forms the four draws there and passes them through a
// two-entry queue. The back end handles one node at a time: a leaf goes
// straight to the done step, an internal node makes three passes through one
// 32x32 multiplier.
// A stalled output holds its request; the queue then fills and o_in_stall
// rises once the holding stage cannot drain.
// Reset restores the register defaults, zeroes the streams and the tree
// counter and empties the queue; the first node afterwards starts a tree.
// ----------------------------------------------------------------------------
module tree_param_lcg_masker_unit
    import tplm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    input  logic              i_out_stall
);

    t_cfg_wr  w_cfg;
    logic     w_push;
    t_q_entry w_push_entry;
    logic     w_full;
    logic     w_q_vld;
    t_q_entry w_q_entry;
    logic     w_pop;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = i_cfg_addr;
    assign w_cfg.data = i_cfg_data;

    tplm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q_vld    (w_push),
        .o_q_entry  (w_push_entry),
        .i_q_full   (w_full)
    );

    tplm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_vld   (w_q_vld),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    tplm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (w_q_vld),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
